### src/rrpt_pkg.sv
// ----------------------------------------------------------------------------
// rrpt_pkg: shared types and constants for the radiometric response terms
// Payload structs, operation, bank and register codes, and output saturation.
// ----------------------------------------------------------------------------
package rrpt_pkg;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Bit 2 of table_select picks the slope bank; bits 1:0 pick the lane
  localparam logic CURVE_BANK = 1'b0;
  localparam logic SLOPE_BANK = 1'b1;

  // Tracking modes
  localparam logic MODE_SLOPES = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

  // Configuration register indexes (byte address 4*index)
  localparam int          APB_ADDR_W = 5;
  localparam logic [2:0]  REG_MODE   = 3'd0;
  localparam logic [2:0]  REG_TERMS  = 3'd1;
  localparam logic [2:0]  REG_COEF1  = 3'd2;
  localparam logic [2:0]  REG_COEF2  = 3'd3;
  localparam logic [2:0]  REG_COEF3  = 3'd4;

  // 255.0 in unsigned Q8.8
  localparam logic [15:0] IRR_FULL_SCALE = 16'hFF00;

  // Datapath widths: weighted sums in Q.20, gradient products, final combine
  localparam int SUM_W  = 34;
  localparam int PROD_W = 50;
  localparam int COMB_W = 52;

  typedef struct packed {
    logic               op;
    logic [2:0]         table_select;
    logic [9:0]         table_index;
    logic signed [15:0] table_value;
    logic [11:0]        pixel_column;
    logic [11:0]        pixel_row;
    logic [15:0]        current_irradiance;
    logic [15:0]        reference_irradiance;
    logic signed [15:0] current_grad_x;
    logic signed [15:0] reference_grad_x;
    logic signed [15:0] current_grad_y;
    logic signed [15:0] reference_grad_y;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_column;
    logic [11:0]        out_row;
    logic signed [31:0] brightness_offset;
    logic signed [31:0] jacobian_x;
    logic signed [31:0] jacobian_y;
  } out_item_t;

  // Per-pixel data carried alongside the lookups
  typedef struct packed {
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] cur_gx;
    logic signed [15:0] ref_gx;
    logic signed [15:0] cur_gy;
    logic signed [15:0] ref_gy;
  } pix_meta_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [COMB_W-1:0] v);
    logic fits;
    fits = (&v[COMB_W-1:31]) || !(|v[COMB_W-1:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[COMB_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

### src/radiometric_response_pixel_terms.sv
// ----------------------------------------------------------------------------
// radiometric_response_pixel_terms
// Curve table lookup of a camera response model: brightness offset and
// x/y Jacobian terms for a current/reference pixel pair, saturated Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  signals                          carries
//  -------  -------------------------------  -----------------------------------
//  req      req_valid, req_ready, req        table write or pixel pair, in
//  rsp      rsp_valid, rsp_ready, rsp        one result per pixel pair, out
//  apb      psel, penable, pwrite, paddr,    mode, term count, coefficients
//           pwdata, prdata, pready
//
//  One item per cycle sustained while rsp is not stalled; a pixel result is
//  registered through stages 0 to 5 and then onto rsp. Both lookups of a pixel
//  hit the curve and slope memories in the same cycle through their two read
//  ports, which sets that rate. Reset clears stage valids and loads register
//  defaults; table contents are undefined until written. A stalled rsp backs up
//  one stage at a time, so req_ready drops only once every stage holds an item.
//
module radiometric_response_pixel_terms #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_TERMS   = 3
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            req_valid,
  output logic                            req_ready,
  input  rrpt_pkg::in_item_t              req,

  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output rrpt_pkg::out_item_t             rsp,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrpt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int T_W   = IDX_W + 8;
  localparam int LANES = MAX_TERMS + 1;
  localparam int SW    = rrpt_pkg::SUM_W;
  localparam int PW    = rrpt_pkg::PROD_W;
  localparam int CW    = rrpt_pkg::COMB_W;
  localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(TABLE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               tracking_mode;
  logic [1:0]         active_terms;
  logic signed [15:0] coef [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_mode <= rrpt_pkg::MODE_SLOPES;
      active_terms  <= 2'd3;
      for (int k = 0; k < 3; k++) begin
        coef[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        rrpt_pkg::REG_MODE:  tracking_mode <= pwdata[0];
        rrpt_pkg::REG_TERMS: active_terms  <= pwdata[1:0];
        rrpt_pkg::REG_COEF1: coef[0]       <= pwdata[15:0];
        rrpt_pkg::REG_COEF2: coef[1]       <= pwdata[15:0];
        rrpt_pkg::REG_COEF3: coef[2]       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rrpt_pkg::REG_MODE:  prdata = {31'b0, tracking_mode};
      rrpt_pkg::REG_TERMS: prdata = {30'b0, active_terms};
      rrpt_pkg::REG_COEF1: prdata = 32'(coef[0]);
      rrpt_pkg::REG_COEF2: prdata = 32'(coef[1]);
      rrpt_pkg::REG_COEF3: prdata = 32'(coef[2]);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage handshake: each stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic v0, v1, v2, v3, v4, v5;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  assign rdy_out   = !rsp_valid || rsp_ready;
  assign rdy5      = !v5 || rdy_out;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign req_ready = rdy0;

  // --------------------------------------------------------------------------
  // Stage 0: register the item, start index quantization
  //   index = floor(irr*(D-1)/65280); split as t = (irr*(D-1))>>8, then t/255
  //   via q0 = (t*257)>>16, which undershoots by at most one
  // --------------------------------------------------------------------------
  rrpt_pkg::in_item_t s0_item;
  logic [15:0]        irr      [2];
  logic [IDX_W+15:0]  scaled   [2];
  logic [T_W-1:0]     t_c      [2];
  logic [T_W+8:0]     tmul     [2];
  logic [IDX_W:0]     q0_c     [2];
  logic               hi_c     [2];

  always_comb begin
    irr[0] = s0_item.current_irradiance;
    irr[1] = s0_item.reference_irradiance;
    for (int n = 0; n < 2; n++) begin
      scaled[n] = (IDX_W+16)'(irr[n]) * (IDX_W+16)'(DEPTH_M1);
      t_c[n]    = scaled[n][IDX_W+15:8];
      tmul[n]   = {1'b0, t_c[n], 8'b0} + (T_W+9)'(t_c[n]);
      q0_c[n]   = tmul[n][T_W+8:16];
      hi_c[n]   = irr[n] >= rrpt_pkg::IRR_FULL_SCALE;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: correct the quotient, clamp, address the memories or write
  // --------------------------------------------------------------------------
  rrpt_pkg::in_item_t s1_item;
  logic [T_W-1:0]     s1_t   [2];
  logic [IDX_W:0]     s1_q0  [2];
  logic               s1_hi  [2];
  logic [T_W:0]       mul255 [2];
  logic [T_W:0]       rem    [2];
  logic [IDX_W:0]     qc     [2];
  logic [IDX_W-1:0]   rd_idx [2];

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      mul255[n] = {s1_q0[n], 8'b0} - (T_W+1)'(s1_q0[n]);
      rem[n]    = (T_W+1)'(s1_t[n]) - mul255[n];
      qc[n]     = s1_q0[n] + (IDX_W+1)'(rem[n] >= (T_W+1)'(255));
      rd_idx[n] = s1_hi[n] ? DEPTH_M1 : qc[n][IDX_W-1:0];
    end
  end

  logic [IDX_W+9:0]  wr_wide;
  logic [IDX_W-1:0]  wr_addr;
  logic [1:0]        wr_lane;
  logic              wr_in_range;
  logic              wr_lane_ok;
  logic              wr_go;
  logic              curve_we;
  logic              slope_we;
  logic              rd_en;

  assign wr_wide     = {IDX_W'(0), s1_item.table_index};
  assign wr_addr     = wr_wide[IDX_W-1:0];
  assign wr_lane     = s1_item.table_select[1:0];
  assign wr_in_range = 14'(s1_item.table_index) < 14'(TABLE_DEPTH);
  assign wr_lane_ok  = 3'(wr_lane) <= 3'(MAX_TERMS);
  // Write when the item leaves stage 1, so a later pixel reads the new entry
  assign wr_go       = rdy2 && v1 && (s1_item.op == rrpt_pkg::OP_WRITE)
                       && wr_in_range && wr_lane_ok;
  assign curve_we    = wr_go && (s1_item.table_select[2] == rrpt_pkg::CURVE_BANK);
  assign slope_we    = wr_go && (s1_item.table_select[2] == rrpt_pkg::SLOPE_BANK);
  assign rd_en       = rdy2;

  // --------------------------------------------------------------------------
  // Table memories: lane 0 base, lanes 1..MAX_TERMS basis; two read ports
  // --------------------------------------------------------------------------
  logic [LANES-1:0][15:0] curve_mem [TABLE_DEPTH];
  logic [LANES-1:0][15:0] slope_mem [TABLE_DEPTH];
  logic [LANES-1:0][15:0] curve_rd  [2];
  logic [LANES-1:0][15:0] slope_rd  [2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (curve_we && (wr_lane == 2'(k))) begin
        curve_mem[wr_addr][k] <= s1_item.table_value;
      end
    end
    if (rd_en) begin
      curve_rd[0] <= curve_mem[rd_idx[0]];
      curve_rd[1] <= curve_mem[rd_idx[1]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (slope_we && (wr_lane == 2'(k))) begin
        slope_mem[wr_addr][k] <= s1_item.table_value;
      end
    end
    if (rd_en) begin
      slope_rd[0] <= slope_mem[rd_idx[0]];
      slope_rd[1] <= slope_mem[rd_idx[1]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weight each lane (base shifted into Q.20, basis times coef)
  // --------------------------------------------------------------------------
  rrpt_pkg::pix_meta_t  s2_meta;
  logic [1:0]           term_n;
  logic [MAX_TERMS-1:0] lane_on;
  logic signed [31:0]   pc_c     [2][LANES];
  logic signed [31:0]   ps_c     [2][LANES];

  assign term_n = (3'(active_terms) > 3'(MAX_TERMS)) ? 2'(MAX_TERMS) : active_terms;

  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      lane_on[k] = 2'(k + 1) <= term_n;
    end
    for (int n = 0; n < 2; n++) begin
      pc_c[n][0] = 32'(signed'(curve_rd[n][0])) <<< 8;
      ps_c[n][0] = 32'(signed'(slope_rd[n][0])) <<< 8;
      // Force an inactive lane to zero; its entries need not be loaded
      for (int k = 1; k < LANES; k++) begin
        pc_c[n][k] = lane_on[k-1] ? 32'(signed'(curve_rd[n][k])) * 32'(coef[k-1])
                                  : 32'sd0;
        ps_c[n][k] = lane_on[k-1] ? 32'(signed'(slope_rd[n][k])) * 32'(coef[k-1])
                                  : 32'sd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum lanes into response and weighted slope
  // --------------------------------------------------------------------------
  rrpt_pkg::pix_meta_t s3_meta;
  logic signed [31:0]  s3_pc [2][LANES];
  logic signed [31:0]  s3_ps [2][LANES];
  logic signed [15:0]  s3_bs [2];
  logic signed [SW-1:0] resp_c [2];
  logic signed [SW-1:0] slp_c  [2];

  always_comb begin
    for (int n = 0; n < 2; n++) begin
      resp_c[n] = '0;
      slp_c[n]  = '0;
      for (int k = 0; k < LANES; k++) begin
        resp_c[n] = resp_c[n] + SW'(s3_pc[n][k]);
        slp_c[n]  = slp_c[n] + SW'(s3_ps[n][k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: offset; slope times gradient (mode picks weighted or base slope)
  // --------------------------------------------------------------------------
  rrpt_pkg::pix_meta_t  s4_meta;
  logic signed [SW-1:0] s4_resp [2];
  logic signed [SW-1:0] s4_slp  [2];
  logic signed [15:0]   s4_bs   [2];
  logic signed [SW-1:0] opnd    [2];
  logic signed [15:0]   gx      [2];
  logic signed [15:0]   gy      [2];
  logic signed [PW-1:0] px_c    [2];
  logic signed [PW-1:0] py_c    [2];
  logic signed [SW:0]   off_c;

  always_comb begin
    gx[0] = s4_meta.cur_gx;
    gx[1] = s4_meta.ref_gx;
    gy[0] = s4_meta.cur_gy;
    gy[1] = s4_meta.ref_gy;
    for (int n = 0; n < 2; n++) begin
      opnd[n] = (tracking_mode == rrpt_pkg::MODE_MEAN) ? SW'(s4_bs[n]) : s4_slp[n];
      px_c[n] = PW'(opnd[n]) * PW'(gx[n]);
      py_c[n] = PW'(opnd[n]) * PW'(gy[n]);
    end
    off_c = (SW+1)'(s4_resp[0]) - (SW+1)'(s4_resp[1]);
  end

  // --------------------------------------------------------------------------
  // Stage 5: combine current and reference, floor shift, saturate
  // --------------------------------------------------------------------------
  rrpt_pkg::pix_meta_t  s5_meta;
  logic signed [PW-1:0] s5_px [2];
  logic signed [PW-1:0] s5_py [2];
  logic signed [SW:0]   s5_off;
  logic signed [CW-1:0] jx_sum, jy_sum, jx_sh, jy_sh, off_sh;
  rrpt_pkg::out_item_t  rsp_next;

  always_comb begin
    if (tracking_mode == rrpt_pkg::MODE_MEAN) begin
      jx_sum = CW'(s5_px[0]) + CW'(s5_px[1]);
      jy_sum = CW'(s5_py[0]) + CW'(s5_py[1]);
      jx_sh  = jx_sum >>> 1;
      jy_sh  = jy_sum >>> 1;
    end else begin
      jx_sum = CW'(s5_px[0]) - CW'(s5_px[1]);
      jy_sum = CW'(s5_py[0]) - CW'(s5_py[1]);
      jx_sh  = jx_sum >>> 8;
      jy_sh  = jy_sum >>> 8;
    end
    off_sh = CW'(s5_off) >>> 4;
    rsp_next.out_column        = s5_meta.column;
    rsp_next.out_row           = s5_meta.row;
    rsp_next.brightness_offset = rrpt_pkg::sat32(off_sh);
    rsp_next.jacobian_x        = rrpt_pkg::sat32(jx_sh);
    rsp_next.jacobian_y        = rrpt_pkg::sat32(jy_sh);
  end

  // --------------------------------------------------------------------------
  // Stage valids; write items drop out after stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rdy0)    v0        <= req_valid;
      if (rdy1)    v1        <= v0;
      if (rdy2)    v2        <= v1 && (s1_item.op == rrpt_pkg::OP_PIXEL);
      if (rdy3)    v3        <= v2;
      if (rdy4)    v4        <= v3;
      if (rdy5)    v5        <= v4;
      if (rdy_out) rsp_valid <= v5;
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_item <= req;
    end
    if (rdy1) begin
      s1_item <= s0_item;
      for (int n = 0; n < 2; n++) begin
        s1_t[n]  <= t_c[n];
        s1_q0[n] <= q0_c[n];
        s1_hi[n] <= hi_c[n];
      end
    end
    if (rdy2) begin
      s2_meta.column <= s1_item.pixel_column;
      s2_meta.row    <= s1_item.pixel_row;
      s2_meta.cur_gx <= s1_item.current_grad_x;
      s2_meta.ref_gx <= s1_item.reference_grad_x;
      s2_meta.cur_gy <= s1_item.current_grad_y;
      s2_meta.ref_gy <= s1_item.reference_grad_y;
    end
    if (rdy3) begin
      s3_meta <= s2_meta;
      for (int n = 0; n < 2; n++) begin
        s3_bs[n] <= slope_rd[n][0];
        for (int k = 0; k < LANES; k++) begin
          s3_pc[n][k] <= pc_c[n][k];
          s3_ps[n][k] <= ps_c[n][k];
        end
      end
    end
    if (rdy4) begin
      s4_meta <= s3_meta;
      for (int n = 0; n < 2; n++) begin
        s4_resp[n] <= resp_c[n];
        s4_slp[n]  <= slp_c[n];
        s4_bs[n]   <= s3_bs[n];
      end
    end
    if (rdy5) begin
      s5_meta <= s4_meta;
      s5_off  <= off_c;
      for (int n = 0; n < 2; n++) begin
        s5_px[n] <= px_c[n];
        s5_py[n] <= py_c[n];
      end
    end
    if (rdy_out) begin
      rsp <= rsp_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The reciprocal estimate leaves a remainder below two divisors
  a_rem_cur: assert property (@(posedge clk) disable iff (rst)
    v1 |-> rem[0] < (T_W+1)'(510))
    else $error("current index remainder out of bound");

  a_rem_ref: assert property (@(posedge clk) disable iff (rst)
    v1 |-> rem[1] < (T_W+1)'(510))
    else $error("reference index remainder out of bound");

  // Input backs up only when every stage is full and the result is stalled
  a_no_early_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready && v0 && v1 && v2 && v3 && v4 && v5))
    else $error("input stalled with room in the pipeline");

  // A stalled last stage keeps its data
  a_s5_hold: assert property (@(posedge clk) disable iff (rst)
    (v5 && !rdy_out) |=> (v5 && $stable(s5_off)))
    else $error("last stage changed while stalled");

endmodule

### tb/radiometric_response_pixel_terms_tb.sv
// ----------------------------------------------------------------------------
// radiometric_response_pixel_terms_tb: self-checking bench for the pixel terms
// Loads curve and slope tables by write transfers, interleaved with streamed pixel pairs
// under several mode, term-count and coefficient settings. An in-bench
// predictor computes offset and Jacobians per pixel, and a scoreboard
// compares every result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module radiometric_response_pixel_terms_tb;

  localparam int          TABLE_DEPTH  = 1024;
  localparam int          MAX_TERMS    = 3;
  localparam int unsigned BIN_LAST     = TABLE_DEPTH - 1;
  localparam logic [2:0]  REG_UNUSED   = 3'd5;   // decoded address with no register
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned DRAIN_CYCLES = 12;     // pipeline is six deep; add margin
  localparam int unsigned HOLD_AT      = 120;    // result count that starts the long stall
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the tables and registers, predicts one result per
  // pixel transfer, and checks results in order.
  // --------------------------------------------------------------------------
  class pixel_terms_scoreboard;
    logic signed [15:0]  curve_mem [8][TABLE_DEPTH];
    bit                  loaded    [8][TABLE_DEPTH];
    bit                  bin_full  [TABLE_DEPTH];
    int unsigned         full_bins [$];
    logic                mode;
    logic [1:0]          terms;
    logic signed [15:0]  coef [3];
    rrpt_pkg::out_item_t expected_terms [$];
    int unsigned         errors;
    int unsigned         checked;

    function new();
      mode    = rrpt_pkg::MODE_SLOPES;
      terms   = 2'd3;
      foreach (coef[k]) coef[k] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int unsigned pending();
      return expected_terms.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        rrpt_pkg::REG_MODE:  mode    = data[0];
        rrpt_pkg::REG_TERMS: terms   = data[1:0];
        rrpt_pkg::REG_COEF1: coef[0] = data[15:0];
        rrpt_pkg::REG_COEF2: coef[1] = data[15:0];
        rrpt_pkg::REG_COEF3: coef[2] = data[15:0];
        default: ;
      endcase
    endfunction

    // Compare only the bits the register holds
    function void check_reg(logic [2:0] idx, logic [31:0] data);
      logic [31:0] want;
      logic [31:0] mask;
      case (idx)
        rrpt_pkg::REG_MODE:  begin want = {31'd0, mode};     mask = 32'h1;    end
        rrpt_pkg::REG_TERMS: begin want = {30'd0, terms};    mask = 32'h3;    end
        rrpt_pkg::REG_COEF1: begin want = {16'd0, coef[0]};  mask = 32'hFFFF; end
        rrpt_pkg::REG_COEF2: begin want = {16'd0, coef[1]};  mask = 32'hFFFF; end
        rrpt_pkg::REG_COEF3: begin want = {16'd0, coef[2]};  mask = 32'hFFFF; end
        default:   return;
      endcase
      if ((data & mask) !== want)
        flag($sformatf("register %0d reads %h, want %h", idx, data & mask, want));
    endfunction

    function int unsigned irr_bin(logic [15:0] irr);
      int unsigned q;
      q = (32'(irr) * BIN_LAST) / 32'(rrpt_pkg::IRR_FULL_SCALE);
      return (q > BIN_LAST) ? BIN_LAST : q;
    endfunction

    // Base entry plus the active coefficient-weighted lanes, Q.20
    function longint weighted(logic bank, int unsigned idx);
      int unsigned sel0;
      int unsigned n;
      longint      acc;
      sel0 = {bank, 2'b00};
      n    = (terms > MAX_TERMS) ? MAX_TERMS : terms;
      acc  = longint'(curve_mem[sel0][idx]) * 256;
      for (int unsigned k = 0; k < n; k++)
        acc += longint'(curve_mem[sel0 + k + 1][idx]) * longint'(coef[k]);
      return acc;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function logic signed [31:0] jacobian_term(int unsigned bc, int unsigned br,
                                               longint gc, longint gr);
      int unsigned s0;
      s0 = {rrpt_pkg::SLOPE_BANK, 2'b00};
      if (mode == rrpt_pkg::MODE_SLOPES)
        return clamp32((weighted(rrpt_pkg::SLOPE_BANK, bc) * gc
                        - weighted(rrpt_pkg::SLOPE_BANK, br) * gr) >>> 8);
      return clamp32((longint'(curve_mem[s0][bc]) * gc + longint'(curve_mem[s0][br]) * gr) >>> 1);
    endfunction

    function rrpt_pkg::out_item_t predict_terms(rrpt_pkg::in_item_t it);
      rrpt_pkg::out_item_t r;
      int unsigned         bc;
      int unsigned         br;
      bc = irr_bin(it.current_irradiance);
      br = irr_bin(it.reference_irradiance);
      r.out_column        = it.pixel_column;
      r.out_row           = it.pixel_row;
      r.brightness_offset = clamp32((weighted(rrpt_pkg::CURVE_BANK, bc)
                                     - weighted(rrpt_pkg::CURVE_BANK, br)) >>> 4);
      r.jacobian_x        = jacobian_term(bc, br, longint'(it.current_grad_x),
                                          longint'(it.reference_grad_x));
      r.jacobian_y        = jacobian_term(bc, br, longint'(it.current_grad_y),
                                          longint'(it.reference_grad_y));
      return r;
    endfunction

    function void note_input(rrpt_pkg::in_item_t it);
      bit all_set;
      if (it.op == rrpt_pkg::OP_WRITE) begin
        curve_mem[it.table_select][it.table_index] = it.table_value;
        loaded[it.table_select][it.table_index]    = 1'b1;
        all_set = 1'b1;
        for (int s = 0; s < 8; s++) all_set &= loaded[s][it.table_index];
        if (all_set && !bin_full[it.table_index]) begin
          bin_full[it.table_index] = 1'b1;
          full_bins = {full_bins, 32'(it.table_index)};
        end
      end else begin
        expected_terms = {expected_terms, predict_terms(it)};
      end
    endfunction

    function void check_result(rrpt_pkg::out_item_t got);
      rrpt_pkg::out_item_t want;
      if (expected_terms.size() == 0) begin
        flag($sformatf("result with nothing outstanding: col %0d row %0d",
                       got.out_column, got.out_row));
        return;
      end
      want = expected_terms.pop_front();
      checked++;
      if (got.out_column !== want.out_column || got.out_row !== want.out_row ||
          got.brightness_offset !== want.brightness_offset ||
          got.jacobian_x !== want.jacobian_x || got.jacobian_y !== want.jacobian_y)
        flag($sformatf({"result %0d mismatch: want col %0d row %0d off %0d jx %0d jy %0d,",
                        " got col %0d row %0d off %0d jx %0d jy %0d"}, checked,
                       want.out_column, want.out_row, want.brightness_offset,
                       want.jacobian_x, want.jacobian_y, got.out_column, got.out_row,
                       got.brightness_offset, got.jacobian_x, got.jacobian_y));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_ready;
  rrpt_pkg::in_item_t              req       = '0;
  logic                            rsp_valid;
  logic                            rsp_ready = 1'b0;
  rrpt_pkg::out_item_t             rsp;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [rrpt_pkg::APB_ADDR_W-1:0] paddr     = '0;
  logic [31:0]                     pwdata    = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  pixel_terms_scoreboard sb = new();

  // Shared run state: no_idle turns off idling on both sides for a phase,
  // holding tells the sender that the long result stall is in progress.
  bit          no_idle      = 1'b0;
  bit          holding      = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned settings     = 0;

  radiometric_response_pixel_terms u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------

  // Mostly uniform, with a bias toward the signed extremes and zero
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Start from all-random bits so the fields a transfer ignores still toggle
  function automatic rrpt_pkg::in_item_t noise_item();
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(rrpt_pkg::in_item_t)-1:0];
  endfunction

  function automatic rrpt_pkg::in_item_t write_item(logic [2:0] sel, int unsigned idx,
                                                    logic [15:0] val);
    rrpt_pkg::in_item_t it;
    it              = noise_item();
    it.op           = rrpt_pkg::OP_WRITE;
    it.table_select = sel;
    it.table_index  = idx[9:0];
    it.table_value  = val;
    return it;
  endfunction

  // Any irradiance that quantizes to the given table index
  function automatic logic [15:0] irr_in_bin(int unsigned k);
    int unsigned lo;
    int unsigned hi;
    lo = (k * 32'(rrpt_pkg::IRR_FULL_SCALE) + BIN_LAST - 1) / BIN_LAST;
    hi = (k == BIN_LAST) ? 32'hFFFF
                         : ((k + 1) * 32'(rrpt_pkg::IRR_FULL_SCALE) + BIN_LAST - 1)
                           / BIN_LAST - 1;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Random pixel pair whose two lookups both land on fully loaded indexes
  function automatic rrpt_pkg::in_item_t pixel_item();
    rrpt_pkg::in_item_t it;
    it                      = noise_item();
    it.op                   = rrpt_pkg::OP_PIXEL;
    it.current_irradiance   = irr_in_bin(sb.full_bins[$urandom_range(0, sb.full_bins.size()-1)]);
    it.reference_irradiance = irr_in_bin(sb.full_bins[$urandom_range(0, sb.full_bins.size()-1)]);
    it.current_grad_x       = pick16();
    it.reference_grad_x     = pick16();
    it.current_grad_y       = pick16();
    it.reference_grad_y     = pick16();
    return it;
  endfunction

  function automatic rrpt_pkg::in_item_t pixel_fixed(logic [11:0] col, logic [11:0] row,
                                                     logic [15:0] ci, logic [15:0] ri,
                                                     logic [15:0] cgx, logic [15:0] rgx,
                                                     logic [15:0] cgy, logic [15:0] rgy);
    rrpt_pkg::in_item_t it;
    it                      = noise_item();
    it.op                   = rrpt_pkg::OP_PIXEL;
    it.pixel_column         = col;
    it.pixel_row            = row;
    it.current_irradiance   = ci;
    it.reference_irradiance = ri;
    it.current_grad_x       = cgx;
    it.reference_grad_x     = rgx;
    it.current_grad_y       = cgy;
    it.reference_grad_y     = rgy;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: offer one transfer, hold it until accepted, then note it.
  // Valid drops only when a gap follows, never in the same step it rises.
  // --------------------------------------------------------------------------
  task automatic send_item(input rrpt_pkg::in_item_t it);
    int unsigned gap;
    gap = (no_idle || holding) ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!req_ready);
    sb.note_input(it);
    items_sent++;
    if (it.op == rrpt_pkg::OP_PIXEL) pixels_sent++;
  endtask

  // Fill one index in all eight tables, in a rotated order
  task automatic load_bin(input int unsigned idx, input bit fixed, input logic [15:0] val);
    int unsigned rot;
    rot = $urandom_range(0, 7);
    for (int s = 0; s < 8; s++)
      send_item(write_item(3'(s + rot), idx, fixed ? val : pick16()));
  endtask

  // Drop valid, wait out every outstanding result, then let the last
  // write transfers clear the pipeline before touching registers.
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port: setup cycle, then access cycle held until pready.
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all();
    reg_read(rrpt_pkg::REG_MODE);
    reg_read(rrpt_pkg::REG_TERMS);
    reg_read(rrpt_pkg::REG_COEF1);
    reg_read(rrpt_pkg::REG_COEF2);
    reg_read(rrpt_pkg::REG_COEF3);
  endtask

  // Write every register, then read the whole set back
  task automatic configure(input logic m, input logic [1:0] n, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [15:0] c3);
    reg_write(rrpt_pkg::REG_MODE,  {31'd0, m});
    reg_write(rrpt_pkg::REG_TERMS, {30'd0, n});
    reg_write(rrpt_pkg::REG_COEF1, {{16{c1[15]}}, c1});
    reg_write(rrpt_pkg::REG_COEF2, {{16{c2[15]}}, c2});
    reg_write(rrpt_pkg::REG_COEF3, {{16{c3[15]}}, c3});
    read_all();
    settings++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus phases
  // --------------------------------------------------------------------------

  // Table extremes at both ends of the index range, clamped and exact
  // full-scale irradiance, equal lookups, and gradient extremes.
  task automatic directed_items();
    load_bin(0, 1'b1, 16'h8000);
    load_bin(BIN_LAST, 1'b1, 16'h7FFF);
    send_item(pixel_fixed(12'h000, 12'hFFF, 16'h0000, 16'hFFFF,
                          16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
    send_item(pixel_fixed(12'hFFF, 12'h000, rrpt_pkg::IRR_FULL_SCALE, 16'h003F,
                          16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
    send_item(pixel_fixed(12'h5A5, 12'hA5A, 16'hFFFF, 16'hFFFF,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(pixel_fixed(12'hA5A, 12'h5A5, 16'h0000, 16'h0000,
                          16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    send_item(pixel_fixed(12'h123, 12'hEDC, 16'h0010, 16'hFFF0,
                          16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001));
    send_item(pixel_fixed(12'h000, 12'h000, rrpt_pkg::IRR_FULL_SCALE, 16'h0000,
                          pick16(), pick16(), pick16(), pick16()));
  endtask

  // Mostly pixels on loaded indexes; some full index loads and some stray
  // single-entry writes that can leave an index partly loaded.
  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned idx;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 || sb.full_bins.size() < 4) begin
        idx = $urandom_range(0, 1) ? $urandom_range(0, BIN_LAST)
                                   : sb.full_bins[$urandom_range(0, sb.full_bins.size()-1)];
        load_bin(idx, 1'b0, 16'h0000);
      end else if (pick < 18) begin
        send_item(write_item(3'($urandom_range(0, 7)), $urandom_range(0, BIN_LAST), pick16()));
      end else begin
        send_item(pixel_item());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: draw a stall before each transfer; once, hold off for a
  // long stretch so the pipeline fills and the request side backs up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        holding   = 1'b0;
      end
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        sb.check_result(rsp);
        results_seen++;
        if (results_seen == HOLD_AT) begin
          stall_left = HOLD_CYCLES;
          holding    = 1'b1;
        end else begin
          stall_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
    end
  end

  // Hang guard: count cycles and give up well past any correct run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A write to an address with no register must change nothing, so the
    // readback that follows still shows the reset values.
    reg_write(REG_UNUSED, $urandom());
    read_all();

    // Extreme coefficients for the directed part so the sums saturate
    configure(rrpt_pkg::MODE_SLOPES, 2'd3, 16'h8000, 16'h7FFF, 16'h8000);
    directed_items();
    settle();

    configure(rrpt_pkg::MODE_MEAN, 2'd3, pick16(), pick16(), pick16());
    random_phase(90);
    settle();

    // Back-to-back stretch: neither side idles
    no_idle = 1'b1;
    configure(rrpt_pkg::MODE_SLOPES, 2'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    random_phase(90);
    settle();
    no_idle = 1'b0;

    configure(rrpt_pkg::MODE_SLOPES, 2'd1, pick16(), pick16(), pick16());
    random_phase(90);
    settle();

    configure(rrpt_pkg::MODE_MEAN, 2'd2, 16'h8000, 16'h8000, 16'h8000);
    random_phase(90);
    settle();

    configure(rrpt_pkg::MODE_SLOPES, 2'd2, pick16(), pick16(), pick16());
    random_phase(90);
    settle();

    $display("covered %0d transfers (%0d pixel pairs), %0d results checked",
             items_sent, pixels_sent, sb.checked);
    $display("over %0d register settings with %0d table indexes fully loaded",
             settings, sb.full_bins.size());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
